### rtl/core/disc_to_strip_coordinate_map_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the disc to strip coordinate map
// Shared concurrent check forms, clocked and with reset disable.
// ---------------------------------------------------------------------------
`ifndef DISC_TO_STRIP_COORDINATE_MAP_TOP_MACROS_SVH
`define DISC_TO_STRIP_COORDINATE_MAP_TOP_MACROS_SVH

// same-cycle implication
`define D2SC_ASSERT_IMPL(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("d2sc check failed");

// next-cycle implication
`define D2SC_ASSERT_NEXT(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("d2sc check failed");

`endif

### rtl/core/d2sc_pkg.sv
// ---------------------------------------------------------------------------
// d2sc_pkg
// Widths, angle constants, arctangent table and shared types of the
// disc to strip coordinate map.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package d2sc_pkg;

	// sizing knobs
	localparam int COORD_BITS    = 12;
	localparam int ANGLE_BITS    = 16;
	localparam int CORDIC_STAGES = 16;

	// fixed field widths
	localparam int RADIUS_BITS    = 11;
	localparam int WIDTH_BITS     = 12;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 12;

	// register indexes
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_DISC_RADIUS = CFG_INDEX_BITS'(0),
		REG_STRIP_WIDTH = CFG_INDEX_BITS'(1)
	} cfg_reg_t;

	// derived arithmetic widths
	localparam int GUARD_SHIFT  = 24;
	localparam int TAB_LEN      = 24;
	localparam int TURN_BITS    = 32;
	localparam int DELTA_BITS   = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 1;
	localparam int SQ_BITS      = 2 * DELTA_BITS - 2;
	localparam int D2_BITS      = SQ_BITS + 1;
	localparam int R2_BITS      = 2 * RADIUS_BITS;
	localparam int ROOT_BITS    = (D2_BITS + 1) / 2;
	localparam int TRIAL_BITS   = 2 * ROOT_BITS;
	localparam int XY_BITS      = DELTA_BITS + GUARD_SHIFT + 2;
	localparam int CORDIC_ITERS = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
	localparam int PIPE_LEN     = (CORDIC_ITERS > ROOT_BITS) ? CORDIC_ITERS : ROOT_BITS;
	localparam int CORE_LAT     = PIPE_LEN + 2;
	localparam int PROD_BITS    = ANGLE_BITS + WIDTH_BITS;

	// angles in 2^-32 turn
	localparam logic [TURN_BITS-1:0] ANG_QUARTER = 32'h4000_0000;
	localparam logic [TURN_BITS-1:0] ANG_HALF    = 32'h8000_0000;
	localparam logic [TURN_BITS-1:0] ANG_THREE_Q = 32'hC000_0000;

	// atan(2^-i) in 2^-32 turn
	localparam logic [TURN_BITS-1:0] ATAN_TURNS [TAB_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef logic signed [DELTA_BITS-1:0] delta_t;

	// distance side result
	typedef struct packed {
		logic                 in_disc;
		logic [ROOT_BITS-1:0] root;
	} dist_t;

	// one result beat
	typedef struct packed {
		logic                   in_disc;
		logic [WIDTH_BITS-1:0]  col;
		logic [RADIUS_BITS-1:0] row;
	} res_t;

endpackage

### rtl/core/d2sc_ifs.sv
// ---------------------------------------------------------------------------
// d2sc channel interfaces
// Valid/ready channels for coordinates, results and register writes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface d2sc_coord_if;
	logic                            valid;
	logic                            ready;
	logic [d2sc_pkg::COORD_BITS-1:0] out_x;
	logic [d2sc_pkg::COORD_BITS-1:0] out_y;

	modport source (output valid, output out_x, output out_y, input ready);
	modport sink   (input valid, input out_x, input out_y, output ready);
endinterface

interface d2sc_result_if;
	logic                             valid;
	logic                             ready;
	logic                             inside_res;
	logic [d2sc_pkg::WIDTH_BITS-1:0]  src_col;
	logic [d2sc_pkg::RADIUS_BITS-1:0] src_row;

	modport source (output valid, output inside_res, output src_col, output src_row,
		input ready);
	modport sink   (input valid, input inside_res, input src_col, input src_row,
		output ready);
endinterface

interface d2sc_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [d2sc_pkg::CFG_INDEX_BITS-1:0] index;
	logic [d2sc_pkg::CFG_DATA_BITS-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/d2sc_cordic.sv
// ---------------------------------------------------------------------------
// d2sc_cordic
// Vectoring CORDIC pipeline, one rotation per stage, then the angle to
// column scaling product.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module d2sc_cordic (
	input  logic                                clk,
	input  logic                                en,
	input  d2sc_pkg::delta_t                    dx,
	input  d2sc_pkg::delta_t                    dy,
	input  logic [d2sc_pkg::WIDTH_BITS-1:0]     width,
	output logic [d2sc_pkg::PROD_BITS-1:0]      prod
);

	localparam int XW = d2sc_pkg::XY_BITS;
	localparam int DW = d2sc_pkg::DELTA_BITS;
	localparam int NS = d2sc_pkg::PIPE_LEN;

	logic signed [XW-1:0]                  x_s    [NS+1];
	logic signed [XW-1:0]                  y_s    [NS+1];
	logic [d2sc_pkg::TURN_BITS-1:0]        z_s    [NS+1];
	logic                                  spec_s [NS+1];

	logic signed [DW-1:0]           vx, vy, ax, ay;
	logic                           spec0;
	logic [d2sc_pkg::TURN_BITS-1:0] z0;

	// fold into the right half plane, catch axis cases
	always_comb begin
		vx    = -dx;
		vy    = -dy;
		ax    = vx;
		ay    = vy;
		spec0 = 1'b0;
		z0    = '0;
		if (vy == '0) begin
			spec0 = 1'b1;
			z0    = vx[DW-1] ? d2sc_pkg::ANG_HALF : '0;
		end else if (vx == '0) begin
			spec0 = 1'b1;
			z0    = vy[DW-1] ? d2sc_pkg::ANG_THREE_Q : d2sc_pkg::ANG_QUARTER;
		end else if (vx[DW-1]) begin
			ax = -vx;
			ay = -vy;
			z0 = d2sc_pkg::ANG_HALF;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= XW'(ax) <<< d2sc_pkg::GUARD_SHIFT;
			y_s[0]    <= XW'(ay) <<< d2sc_pkg::GUARD_SHIFT;
			z_s[0]    <= z0;
			spec_s[0] <= spec0;
		end
	end

	// rotation stages
	for (genvar k = 1; k <= NS; k++) begin : g_stage
		localparam int I = k - 1;
		if (I < d2sc_pkg::CORDIC_ITERS) begin : g_rot
			logic signed [XW-1:0] xs, ys;
			assign xs = x_s[k-1] >>> I;
			assign ys = y_s[k-1] >>> I;
			always_ff @(posedge clk) begin
				if (en) begin
					spec_s[k] <= spec_s[k-1];
					if (spec_s[k-1]) begin
						x_s[k] <= x_s[k-1];
						y_s[k] <= y_s[k-1];
						z_s[k] <= z_s[k-1];
					end else if (!y_s[k-1][XW-1]) begin
						x_s[k] <= x_s[k-1] + ys;
						y_s[k] <= y_s[k-1] - xs;
						z_s[k] <= z_s[k-1] + d2sc_pkg::ATAN_TURNS[I];
					end else begin
						x_s[k] <= x_s[k-1] - ys;
						y_s[k] <= y_s[k-1] + xs;
						z_s[k] <= z_s[k-1] - d2sc_pkg::ATAN_TURNS[I];
					end
				end
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				if (en) begin
					spec_s[k] <= spec_s[k-1];
					x_s[k]    <= x_s[k-1];
					y_s[k]    <= y_s[k-1];
					z_s[k]    <= z_s[k-1];
				end
			end
		end
	end

	// angle from upward direction, scaled by strip width
	logic [d2sc_pkg::TURN_BITS-1:0]  turn;
	logic [d2sc_pkg::ANGLE_BITS-1:0] theta;
	logic [d2sc_pkg::PROD_BITS-1:0]  prod_s;

	assign turn  = d2sc_pkg::ANG_QUARTER - z_s[NS];
	assign theta = turn[d2sc_pkg::TURN_BITS-1 -: d2sc_pkg::ANGLE_BITS];

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s <= d2sc_pkg::PROD_BITS'(theta) * d2sc_pkg::PROD_BITS'(width);
		end
	end

	assign prod = prod_s;

endmodule

### rtl/core/d2sc_isqrt.sv
// ---------------------------------------------------------------------------
// d2sc_isqrt
// Squared distance, inside test and a restoring integer square root,
// one root bit per stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module d2sc_isqrt (
	input  logic                             clk,
	input  logic                             en,
	input  d2sc_pkg::delta_t                 dx,
	input  d2sc_pkg::delta_t                 dy,
	input  logic [d2sc_pkg::RADIUS_BITS-1:0] radius,
	output d2sc_pkg::dist_t                  dinfo
);

	localparam int NS = d2sc_pkg::PIPE_LEN;
	localparam int RB = d2sc_pkg::ROOT_BITS;
	localparam int TB = d2sc_pkg::TRIAL_BITS;

	logic [d2sc_pkg::SQ_BITS-1:0] sqx_s0, sqy_s0;
	logic [d2sc_pkg::R2_BITS-1:0] r2_s0;

	// squares
	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s0 <= d2sc_pkg::SQ_BITS'(dx * dx);
			sqy_s0 <= d2sc_pkg::SQ_BITS'(dy * dy);
			r2_s0  <= d2sc_pkg::R2_BITS'(radius) * d2sc_pkg::R2_BITS'(radius);
		end
	end

	logic [TB-1:0] rem_s  [NS+1];
	logic [RB-1:0] root_s [NS+1];
	logic          in_s   [NS+1];

	logic [d2sc_pkg::D2_BITS-1:0] d2;
	assign d2 = d2sc_pkg::D2_BITS'(sqx_s0) + d2sc_pkg::D2_BITS'(sqy_s0);

	// sum and radius compare
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= TB'(d2);
			root_s[0] <= '0;
			in_s[0]   <= (d2 <= d2sc_pkg::D2_BITS'(r2_s0));
		end
	end

	// root digits, most significant first
	for (genvar k = 1; k <= NS; k++) begin : g_step
		localparam int J = k - 1;
		if (J < RB) begin : g_bit
			localparam int B = RB - 1 - J;
			logic [TB-1:0] trial;
			assign trial = (TB'(root_s[k-1]) << (B + 1)) | (TB'(1) << (2 * B));
			always_ff @(posedge clk) begin
				if (en) begin
					in_s[k] <= in_s[k-1];
					if (rem_s[k-1] >= trial) begin
						rem_s[k]  <= rem_s[k-1] - trial;
						root_s[k] <= root_s[k-1] | (RB'(1) << B);
					end else begin
						rem_s[k]  <= rem_s[k-1];
						root_s[k] <= root_s[k-1];
					end
				end
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				if (en) begin
					in_s[k]   <= in_s[k-1];
					rem_s[k]  <= rem_s[k-1];
					root_s[k] <= root_s[k-1];
				end
			end
		end
	end

	assign dinfo.in_disc = in_s[NS];
	assign dinfo.root    = root_s[NS];

endmodule

### rtl/core/disc_to_strip_coordinate_map_top.sv
// ---------------------------------------------------------------------------
// disc_to_strip_coordinate_map_top
// Maps an output disc pixel to the strip image pixel to fetch: angle from
// a pipelined CORDIC gives the column, integer root of the distance the row.
//
//  channel  dir  beat contents                      accept
//  coord    in   out_x, out_y                       valid & ready
//  result   out  inside_res, src_col, src_row       valid & ready
//  cfg      in   index, data (radius, strip width)  valid & ready (always ready)
//
// One coordinate per cycle while the pipe is not held; a result is registered
// through the 16 CORDIC rotation stages (root bits run alongside).
// arst_n clears valid bits and loads radius 648, strip width 1280.
// A stalled result sits in the output register, a skid entry takes one more;
// the whole pipe then holds until the result beat is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module disc_to_strip_coordinate_map_top (
	input  logic           clk,
	input  logic           arst_n,
	d2sc_coord_if.sink     coord,
	d2sc_result_if.source  result,
	d2sc_cfg_if.sink       cfg
);

	localparam int RB = d2sc_pkg::RADIUS_BITS;
	localparam int WB = d2sc_pkg::WIDTH_BITS;

	logic [RB-1:0] radius_q;
	logic [WB-1:0] width_q;

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RB'(648);
			width_q  <= WB'(1280);
		end else if (cfg.valid) begin
			unique case (d2sc_pkg::cfg_reg_t'(cfg.index))
				d2sc_pkg::REG_DISC_RADIUS: radius_q <= cfg.data[RB-1:0];
				d2sc_pkg::REG_STRIP_WIDTH: width_q  <= cfg.data[WB-1:0];
				default: ;
			endcase
		end
	end

	// pipe advance: held only while the skid entry is full
	logic en;
	logic skid_vld_q;

	assign en          = !skid_vld_q;
	assign coord.ready = en;

	// offsets from the centre
	logic             vld_s1;
	d2sc_pkg::delta_t dx_s1, dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= coord.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= $signed(d2sc_pkg::DELTA_BITS'(coord.out_x))
				- $signed(d2sc_pkg::DELTA_BITS'(radius_q));
			dy_s1 <= $signed(d2sc_pkg::DELTA_BITS'(coord.out_y))
				- $signed(d2sc_pkg::DELTA_BITS'(radius_q));
		end
	end

	// angle and distance units
	logic [d2sc_pkg::PROD_BITS-1:0] prod;
	d2sc_pkg::dist_t                dinfo;

	d2sc_cordic u_cordic (
		.clk   (clk),
		.en    (en),
		.dx    (dx_s1),
		.dy    (dy_s1),
		.width (width_q),
		.prod  (prod)
	);

	d2sc_isqrt u_isqrt (
		.clk    (clk),
		.en     (en),
		.dx     (dx_s1),
		.dy     (dy_s1),
		.radius (radius_q),
		.dinfo  (dinfo)
	);

	// valid bits alongside the units
	logic vld_core_s [d2sc_pkg::CORE_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < d2sc_pkg::CORE_LAT; k++) begin
				vld_core_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_core_s[0] <= vld_s1;
			for (int k = 1; k < d2sc_pkg::CORE_LAT; k++) begin
				vld_core_s[k] <= vld_core_s[k-1];
			end
		end
	end

	// clamps and outside masking
	logic [WB-1:0]                  col_raw;
	logic [d2sc_pkg::ROOT_BITS-1:0] row_lim;
	d2sc_pkg::res_t                 res_new;

	assign col_raw = prod[d2sc_pkg::ANGLE_BITS +: WB];
	assign row_lim = d2sc_pkg::ROOT_BITS'(radius_q) - d2sc_pkg::ROOT_BITS'(1);

	always_comb begin
		res_new.in_disc = dinfo.in_disc;
		if (width_q == '0) begin
			res_new.col = '0;
		end else if (col_raw >= width_q) begin
			res_new.col = width_q - WB'(1);
		end else begin
			res_new.col = col_raw;
		end
		if (radius_q == '0) begin
			res_new.row = '0;
		end else if (dinfo.root > row_lim) begin
			res_new.row = row_lim[RB-1:0];
		end else begin
			res_new.row = dinfo.root[RB-1:0];
		end
		if (!dinfo.in_disc) begin
			res_new.col = '0;
			res_new.row = '0;
		end
	end

	// output register and skid entry
	logic           out_vld_q;
	d2sc_pkg::res_t out_q, skid_q;
	logic           take, incoming;

	assign take     = out_vld_q && result.ready;
	assign incoming = en && vld_core_s[d2sc_pkg::CORE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || take) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= incoming;
			end
		end else if (incoming) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || take) begin
			out_q <= skid_vld_q ? skid_q : res_new;
		end else if (incoming) begin
			skid_q <= res_new;
		end
	end

	assign result.valid      = out_vld_q;
	assign result.inside_res = out_q.in_disc;
	assign result.src_col    = out_q.col;
	assign result.src_row    = out_q.row;

endmodule

### rtl/core/d2sc_checker.sv
// ---------------------------------------------------------------------------
// d2sc_checker
// Port-level checks on the coordinate map, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "disc_to_strip_coordinate_map_top_macros.svh"

module d2sc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             coord_ready,
	input logic                             res_valid,
	input logic                             res_ready,
	input logic                             res_inside,
	input logic [d2sc_pkg::WIDTH_BITS-1:0]  res_col,
	input logic [d2sc_pkg::RADIUS_BITS-1:0] res_row
);

	// a waiting result beat stays
	`D2SC_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid)

	// and keeps its contents
	`D2SC_ASSERT_NEXT(a_res_stable, clk, arst_n, res_valid && !res_ready, $stable(res_inside) && $stable(res_col) && $stable(res_row))

	// empty output means the skid is empty, so coordinates are taken
	`D2SC_ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !res_valid, coord_ready)

	// pixels outside the disc give zero coordinates
	`D2SC_ASSERT_IMPL(a_outside_zero, clk, arst_n, res_valid && !res_inside, res_col == '0 && res_row == '0)

endmodule

bind disc_to_strip_coordinate_map_top d2sc_checker u_d2sc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.coord_ready (coord.ready),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_inside  (result.inside_res),
	.res_col     (result.src_col),
	.res_row     (result.src_row)
);

### bench/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Checks the disc to strip coordinate map. Coordinate beats come from a
// backlog queue. Each accepted beat is mapped by a local fixed-point model
// (CORDIC angle and integer root) into an expected strip pixel. Result beats
// are compared in order against those expectations. Both sides idle at
// random. Phases change the disc radius and the strip width.
// ---------------------------------------------------------------------------

module tb;

	localparam int CW          = d2sc_pkg::COORD_BITS;
	localparam int RB          = d2sc_pkg::RADIUS_BITS;
	localparam int WB          = d2sc_pkg::WIDTH_BITS;
	localparam int COORD_MAX   = (1 << CW) - 1;
	localparam int TURN_STAGES = 16;
	localparam int TURN_FRAC   = 16;
	localparam int N_PHASES    = 10;
	localparam int RAND_ITEMS  = 115;
	localparam int LONG_HOLD   = 400;
	localparam int HOME_RADIUS = 648;
	localparam int HOME_WIDTH  = 1280;

	localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;
	localparam logic [31:0] TURN_HALF    = 32'h8000_0000;
	localparam logic [31:0] TURN_3Q      = 32'hC000_0000;

	// atan(2^-i) in 2^-32 turn, stage 0 in the top word
	localparam logic [TURN_STAGES*32-1:0] ATAN_STEP = {
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
	};

	typedef struct {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
	} coord_pair_t;

	typedef struct {
		logic [CW-1:0]  x;
		logic [CW-1:0]  y;
		d2sc_pkg::res_t pix;
	} strip_fetch_t;

	logic clk;
	logic arst_n;

	d2sc_coord_if  coord_ch ();
	d2sc_result_if res_ch ();
	d2sc_cfg_if    cfg_ch ();

	disc_to_strip_coordinate_map_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.coord  (coord_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	coord_pair_t  coord_backlog [$];
	strip_fetch_t fetch_expected [$];

	logic [RB-1:0] cur_radius = RB'(HOME_RADIUS);
	logic [WB-1:0] cur_width  = WB'(HOME_WIDTH);

	int  n_err    = 0;
	int  n_pushed = 0;
	int  n_taken  = 0;
	bit  coord_took = 0;
	bit  res_took   = 0;

	// sender pacing
	int  src_gap   = 0;
	bit  src_burst = 0;
	bit  src_fast  = 0;

	// receiver pacing
	int  snk_gap   = 0;
	bit  snk_burst = 0;
	int  hold_req  = 0;
	int  hold_seen = 0;
	int  hold_left = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#(2_000_000);
		$display("== FAIL ==");
		$finish;
	end

	// strip pixel to fetch for one disc pixel under a given radius and width
	function automatic d2sc_pkg::res_t strip_pixel_of(logic [CW-1:0] px, logic [CW-1:0] py,
		logic [RB-1:0] rad, logic [WB-1:0] sw);
		longint xl, yl, rl, wl, dx, dy, d2, r2;
		longint vx, vy, xa, ya, xs, ys;
		longint rem, root, bitv;
		logic [31:0] z, t;
		longint theta, col;
		d2sc_pkg::res_t o;
		xl = px;
		yl = py;
		rl = rad;
		wl = sw;
		dx = xl - rl;
		dy = yl - rl;
		d2 = dx * dx + dy * dy;
		r2 = rl * rl;
		o = '0;
		if (d2 <= r2) begin
			o.in_disc = 1'b1;
			// angle of (-dx, -dy), quadrant folded then rotated to zero
			vx = -dx;
			vy = -dy;
			z = '0;
			if (vy == 0) begin
				z = (vx < 0) ? TURN_HALF : 32'd0;
			end else if (vx == 0) begin
				z = (vy > 0) ? TURN_QUARTER : TURN_3Q;
			end else begin
				if (vx < 0) begin
					vx = -vx;
					vy = -vy;
					z = TURN_HALF;
				end
				xa = vx <<< 24;
				ya = vy <<< 24;
				for (int i = 0; i < TURN_STAGES; i++) begin
					xs = xa >>> i;
					ys = ya >>> i;
					if (ya >= 0) begin
						xa = xa + ys;
						ya = ya - xs;
						z = z + ATAN_STEP[32*(TURN_STAGES-1-i) +: 32];
					end else begin
						xa = xa - ys;
						ya = ya + xs;
						z = z - ATAN_STEP[32*(TURN_STAGES-1-i) +: 32];
					end
				end
			end
			// measured from up, then scaled by strip width
			t = TURN_QUARTER - z;
			theta = t >> (32 - TURN_FRAC);
			col = 0;
			if (wl != 0) begin
				col = (theta * wl) >> TURN_FRAC;
				if (col >= wl)
					col = wl - 1;
			end
			o.col = WB'(col);
			// floored root of d2
			rem = d2;
			root = 0;
			bitv = 1;
			bitv = bitv << 40;
			while (bitv > rem)
				bitv = bitv >> 2;
			while (bitv != 0) begin
				if (rem >= root + bitv) begin
					rem = rem - (root + bitv);
					root = (root >> 1) + bitv;
				end else begin
					root = root >> 1;
				end
				bitv = bitv >> 2;
			end
			if (rl == 0)
				root = 0;
			else if (root > rl - 1)
				root = rl - 1;
			o.row = RB'(root);
		end
		return o;
	endfunction

	task automatic report_mismatch(input string msg);
		n_err++;
		if (n_err <= 30)
			$display("mismatch @%0t: %s", $realtime, msg);
	endtask

	// beats on both channels, sampled at the rising edge
	always @(posedge clk) begin : beat_monitor
		strip_fetch_t want;
		res_took = arst_n && res_ch.valid && res_ch.ready;
		coord_took = arst_n && coord_ch.valid && coord_ch.ready;
		if (res_took) begin
			if (fetch_expected.size() == 0) begin
				report_mismatch($sformatf("result beat with none pending (in=%0d col=%0d row=%0d)",
					res_ch.inside_res, res_ch.src_col, res_ch.src_row));
			end else begin
				want = fetch_expected.pop_front();
				if (res_ch.inside_res !== want.pix.in_disc)
					report_mismatch($sformatf("(%0d,%0d) inside got %0d want %0d",
						want.x, want.y, res_ch.inside_res, want.pix.in_disc));
				if (res_ch.src_col !== want.pix.col)
					report_mismatch($sformatf("(%0d,%0d) col got %0d want %0d",
						want.x, want.y, res_ch.src_col, want.pix.col));
				if (res_ch.src_row !== want.pix.row)
					report_mismatch($sformatf("(%0d,%0d) row got %0d want %0d",
						want.x, want.y, res_ch.src_row, want.pix.row));
			end
		end
		if (coord_took) begin
			want.x = coord_ch.out_x;
			want.y = coord_ch.out_y;
			want.pix = strip_pixel_of(coord_ch.out_x, coord_ch.out_y, cur_radius, cur_width);
			fetch_expected = {fetch_expected, want};
			n_taken++;
		end
	end

	// coordinate driver: holds a beat until taken, then waits its gap
	always @(negedge clk) begin : coord_driver
		coord_pair_t nxt;
		if (!arst_n) begin
			coord_ch.valid <= 1'b0;
		end else if (!coord_ch.valid || coord_took) begin
			if (src_gap > 0) begin
				src_gap--;
				coord_ch.valid <= 1'b0;
			end else if (coord_backlog.size() > 0) begin
				nxt = coord_backlog.pop_front();
				coord_ch.valid <= 1'b1;
				coord_ch.out_x <= nxt.x;
				coord_ch.out_y <= nxt.y;
				if ($urandom_range(0, 19) == 0)
					src_burst = !src_burst;
				src_gap = (src_burst || src_fast) ? 0 : $urandom_range(0, 17);
			end else begin
				coord_ch.valid <= 1'b0;
			end
		end
	end

	// result receiver: per-beat stall, plus an occasional long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = LONG_HOLD;
			end
			if (res_took) begin
				if ($urandom_range(0, 19) == 0)
					snk_burst = !snk_burst;
				snk_gap = snk_burst ? 0 : $urandom_range(0, 17);
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (snk_gap > 0) begin
				snk_gap--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input d2sc_pkg::cfg_reg_t idx, input int val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= d2sc_pkg::CFG_DATA_BITS'(val);
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (idx)
			d2sc_pkg::REG_DISC_RADIUS: cur_radius = RB'(val);
			d2sc_pkg::REG_STRIP_WIDTH: cur_width  = WB'(val);
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic push_coord(input int x, input int y);
		coord_pair_t c;
		if (x < 0) x = 0;
		if (x > COORD_MAX) x = COORD_MAX;
		if (y < 0) y = 0;
		if (y > COORD_MAX) y = COORD_MAX;
		c.x = CW'(x);
		c.y = CW'(y);
		coord_backlog = {coord_backlog, c};
		n_pushed++;
	endtask

	// centre, the four axis ends, a near-edge diagonal, just outside, corners
	task automatic push_landmarks(input int r);
		push_coord(r, r);
		push_coord(r, 0);
		push_coord(r, 2 * r);
		push_coord(0, r);
		push_coord(2 * r, r);
		push_coord(r - (r * 7) / 10, r - (r * 7) / 10);
		push_coord(r, 2 * r + 1);
		push_coord(0, 0);
		push_coord(COORD_MAX, COORD_MAX);
		push_coord(COORD_MAX, 0);
		push_coord(0, COORD_MAX);
	endtask

	// mostly points in or near the disc, the rest anywhere
	task automatic push_random(input int r);
		int sel, dx, dy;
		sel = $urandom_range(0, 9);
		if (sel < 3) begin
			push_coord($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
		end else if (sel == 3) begin
			dx = $urandom_range(0, 6);
			dy = $urandom_range(0, 6);
			push_coord(r + dx - 3, r + dy - 3);
		end else if (sel < 6) begin
			// on or one past the rim
			dx = $urandom_range(0, 2 * r);
			dx = dx - r;
			dy = int'($floor($sqrt(real'(r * r - dx * dx))));
			dy = dy + $urandom_range(0, 1);
			if ($urandom_range(0, 1))
				dy = -dy;
			if ($urandom_range(0, 1))
				push_coord(r + dx, r + dy);
			else
				push_coord(r + dy, r + dx);
		end else begin
			dx = $urandom_range(0, 2 * r);
			dy = $urandom_range(0, 2 * r);
			push_coord(dx, dy);
		end
	endtask

	task automatic wait_idle();
		while (n_taken != n_pushed || fetch_expected.size() != 0)
			@(negedge clk);
	endtask

	// stimulus phases
	initial begin
		int r, w;
		coord_ch.valid = 1'b0;
		coord_ch.out_x = '0;
		coord_ch.out_y = '0;
		res_ch.ready   = 1'b0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.index   = d2sc_pkg::REG_DISC_RADIUS;
		cfg_ch.data    = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: begin r = HOME_RADIUS; w = HOME_WIDTH; end
				1: begin r = 2047; w = 4095; end
				2: begin r = 1; w = 1; end
				3: begin r = 0; w = 0; end
				4: begin r = 2047; w = 1; end
				5: begin r = 1; w = 4095; end
				default: begin
					r = $urandom_range(1, 2047);
					w = $urandom_range(1, 4095);
				end
			endcase
			// registers change only with the pipe empty
			if (ph > 0) begin
				write_reg(d2sc_pkg::REG_DISC_RADIUS, r);
				write_reg(d2sc_pkg::REG_STRIP_WIDTH, w);
			end
			@(posedge clk);
			// full-rate offers against a stalled receiver
			if (ph == 1 || ph == 7) begin
				src_fast = 1'b1;
				hold_req++;
			end
			if (ph <= 1)
				push_landmarks(r);
			if (ph == 3) begin
				push_coord(0, 0);
				push_coord(1, 0);
				push_coord(0, 1);
				push_coord(COORD_MAX, COORD_MAX);
			end
			repeat (RAND_ITEMS)
				push_random(r);
			wait_idle();
			src_fast = 1'b0;
		end

		repeat (40) @(posedge clk);
		if (n_err == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
